>>> hdl/rldm_pkg.sv
package rldm_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  // register indexes
  localparam logic [2:0] REG_COEF_A       = 3'd0;
  localparam logic [2:0] REG_COEF_B       = 3'd1;
  localparam logic [2:0] REG_COEF_C       = 3'd2;
  localparam logic [2:0] REG_COEF_D       = 3'd3;
  localparam logic [2:0] REG_RADIUS_SCALE = 3'd4;
  localparam logic [2:0] REG_CENTER_X2    = 3'd5;
  localparam logic [2:0] REG_CENTER_Y2    = 3'd6;

  // widths of the radius datapath
  localparam int unsigned SqW   = 25;  // dx2^2 + dy2^2 with |dx2|, |dy2| up to 4094
  localparam int unsigned RadW  = 17;  // floor sqrt of (sumsq << 8)
  localparam int unsigned RadIn = 2 * RadW;

endpackage

>>> hdl/rldm_sqrt.sv
module rldm_sqrt
  import rldm_pkg::*;
#(
  parameter int unsigned TagW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [RadIn-1:0]      in_value,
  input  logic [TagW-1:0]       in_tag,
  output logic                  out_valid,
  output logic [RadW-1:0]       out_root,
  output logic [TagW-1:0]       out_tag
);

  // one result bit per stage, restoring method, remainder carried along
  localparam int unsigned NStage = RadW;
  localparam int unsigned RemW   = RadW + 2;

  logic [NStage:0]            vld;
  logic [RadIn-1:0]           num   [NStage+1];
  logic [RadW-1:0]            root  [NStage+1];
  logic [RemW-1:0]            rem   [NStage+1];
  logic [TagW-1:0]            tag   [NStage+1];

  always_comb begin
    vld[0]  = in_valid;
    num[0]  = in_value;
    root[0] = '0;
    rem[0]  = '0;
    tag[0]  = in_tag;
  end

  for (genvar s = 0; s < NStage; s++) begin : g_stage
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic            fits;

    // bring down the next two bits and try root*4+1
    always_comb begin
      rem_sh = {rem[s][RemW-3:0], num[s][RadIn-1 -: 2]};
      trial  = {root[s], 2'b01};
      fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      num[s+1]  <= {num[s][RadIn-3:0], 2'b00};
      root[s+1] <= {root[s][RadW-2:0], fits};
      rem[s+1]  <= fits ? (rem_sh - trial) : rem_sh;
      tag[s+1]  <= tag[s];
    end
  end

  assign out_valid = vld[NStage];
  assign out_root  = root[NStage];
  assign out_tag   = tag[NStage];

endmodule

>>> hdl/radial_lens_distortion_map_unit.sv
// channel   direction  handshake        payload
// request   in         start / busy     pixel_x, pixel_y
// result    out        done strobe      source_x, source_y, clipped
// config    in         cfg_valid/ready  cfg_index, cfg_data
//
// one request accepted every cycle; busy is held low
// done marks each result at the end of the pipeline, which holds the 17-stage square root
// pipeline and, after it, the three Horner multiply stages
// rst is synchronous, clears all valid bits and loads the configuration registers with their defaults
// the receiver cannot stall, so results leave on done without back pressure
module radial_lens_distortion_map_unit
  import rldm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         pixel_x,
  input  logic [9:0]         pixel_y,
  output logic               done,
  output logic signed [15:0] source_x,
  output logic signed [15:0] source_y,
  output logic               clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic [9:0] XMax = 10'((MAX_WIDTH  > 1024 ? 1024 : MAX_WIDTH)  - 1);
  localparam logic [9:0] YMax = 10'((MAX_HEIGHT > 1024 ? 1024 : MAX_HEIGHT) - 1);
  localparam int unsigned TagW = 26;

  logic signed [15:0] coef_a, coef_b, coef_c, coef_d;
  logic [15:0]        radius_scale;
  logic [11:0]        center_x2, center_y2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a       <= 16'sd1229;
      coef_b       <= 16'sd0;
      coef_c       <= 16'sd410;
      coef_d       <= 16'sd4096;
      radius_scale <= 16'd273;
      center_x2    <= 12'd640;
      center_y2    <= 12'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_A:       coef_a       <= cfg_data;
        REG_COEF_B:       coef_b       <= cfg_data;
        REG_COEF_C:       coef_c       <= cfg_data;
        REG_COEF_D:       coef_d       <= cfg_data;
        REG_RADIUS_SCALE: radius_scale <= cfg_data;
        REG_CENTER_X2:    center_x2    <= cfg_data[11:0];
        REG_CENTER_Y2:    center_y2    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // stage 1: clamp and centre offsets in half pixels
  logic              v1;
  logic signed [12:0] dx1, dy1;
  logic [9:0]        cx, cy;

  always_comb begin
    cx = (pixel_x > XMax) ? XMax : pixel_x;
    cy = (pixel_y > YMax) ? YMax : pixel_y;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
    dx1 <= $signed({2'b00, cx, 1'b1}) - $signed({1'b0, center_x2});
    dy1 <= $signed({2'b00, cy, 1'b1}) - $signed({1'b0, center_y2});
  end

  // stage 2: squares
  logic               v2;
  logic [23:0]        sqx, sqy;
  logic signed [12:0] dx2, dy2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    sqx <= 24'(dx1 * dx1);
    sqy <= 24'(dy1 * dy1);
    dx2 <= dx1;
    dy2 <= dy1;
  end

  // stage 3: sum of squares
  logic               v3;
  logic [SqW-1:0]     sumsq;
  logic signed [12:0] dx3, dy3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    sumsq <= SqW'(sqx + sqy);
    dx3   <= dx2;
    dy3   <= dy2;
  end

  // square root pipeline, offsets ride along as a tag
  logic              vs;
  logic [RadW-1:0]   r4;
  logic [TagW-1:0]   tag_s;

  rldm_sqrt #(.TagW(TagW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_value  ({1'b0, sumsq, 8'h00}),
    .in_tag    ({dx3, dy3}),
    .out_valid (vs),
    .out_root  (r4),
    .out_tag   (tag_s)
  );

  // stage: radius times scale
  logic               v4;
  logic [32:0]        rprod;
  logic signed [12:0] dx4, dy4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= vs;
    rprod <= r4 * radius_scale;
    dx4   <= tag_s[25:13];
    dy4   <= tag_s[12:0];
  end

  // stage: round and saturate normalised radius
  logic               v5, clip5;
  logic [15:0]        rn5;
  logic signed [12:0] dx5, dy5;
  logic [23:0]        rn_full;

  assign rn_full = 24'((34'(rprod) + 34'd256) >> 9);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    clip5 <= (rn_full > 24'd65535);
    rn5   <= (rn_full > 24'd65535) ? 16'hFFFF : rn_full[15:0];
    dx5   <= dx4;
    dy5   <= dy4;
  end

  // horner steps: multiply stage then round-and-add stage
  function automatic logic signed [47:0] rnd12(input logic signed [47:0] v);
    logic signed [47:0] a;
    begin
      a = (v < 0) ? -v : v;
      a = (a + 48'sd2048) >>> 12;
      return (v < 0) ? -a : a;
    end
  endfunction

  logic               v6, clip6;
  logic signed [33:0] p6;
  logic [15:0]        rn6;
  logic signed [12:0] dx6, dy6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    p6    <= 34'(coef_a * $signed({1'b0, rn5}));
    rn6   <= rn5;
    clip6 <= clip5;
    dx6   <= dx5;
    dy6   <= dy5;
  end

  logic               v7, clip7;
  logic signed [22:0] f7;
  logic [15:0]        rn7;
  logic signed [12:0] dx7, dy7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    f7    <= 23'(rnd12(48'(p6)) + 48'(coef_b));
    rn7   <= rn6;
    clip7 <= clip6;
    dx7   <= dx6;
    dy7   <= dy6;
  end

  logic               v8, clip8;
  logic signed [40:0] p8;
  logic [15:0]        rn8;
  logic signed [12:0] dx8, dy8;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
    p8    <= 41'(f7 * $signed({1'b0, rn7}));
    rn8   <= rn7;
    clip8 <= clip7;
    dx8   <= dx7;
    dy8   <= dy7;
  end

  logic               v9, clip9;
  logic signed [29:0] f9;
  logic [15:0]        rn9;
  logic signed [12:0] dx9, dy9;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else     v9 <= v8;
    f9    <= 30'(rnd12(48'(p8)) + 48'(coef_c));
    rn9   <= rn8;
    clip9 <= clip8;
    dx9   <= dx8;
    dy9   <= dy8;
  end

  logic               v10, clip10;
  logic signed [46:0] p10;
  logic signed [12:0] dx10, dy10;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else     v10 <= v9;
    p10    <= 47'(f9 * $signed({1'b0, rn9}));
    clip10 <= clip9;
    dx10   <= dx9;
    dy10   <= dy9;
  end

  logic               v11, clip11;
  logic signed [35:0] f11;
  logic signed [12:0] dx11, dy11;

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else     v11 <= v10;
    f11    <= 36'(rnd12(48'(p10)) + 48'(coef_d));
    clip11 <= clip10;
    dx11   <= dx10;
    dy11   <= dy10;
  end

  // scale offsets by the factor
  logic               v12, clip12;
  logic signed [47:0] px12, py12;

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else     v12 <= v11;
    px12   <= 48'(f11 * dx11);
    py12   <= 48'(f11 * dy11);
    clip12 <= clip11;
  end

  // round, add centre, saturate
  function automatic logic signed [47:0] rnd9(input logic signed [47:0] v);
    logic signed [47:0] a;
    begin
      a = (v < 0) ? -v : v;
      a = (a + 48'sd256) >>> 9;
      return (v < 0) ? -a : a;
    end
  endfunction

  logic signed [47:0] sx, sy;
  logic               satx, saty;

  always_comb begin
    sx   = rnd9(px12) + 48'({center_x2, 3'b000});
    sy   = rnd9(py12) + 48'({center_y2, 3'b000});
    satx = (sx > 48'sd32767) || (sx < -48'sd32768);
    saty = (sy > 48'sd32767) || (sy < -48'sd32768);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v12;
    source_x <= (sx > 48'sd32767) ? 16'sh7FFF : (sx < -48'sd32768) ? 16'sh8000 : sx[15:0];
    source_y <= (sy > 48'sd32767) ? 16'sh7FFF : (sy < -48'sd32768) ? 16'sh8000 : sy[15:0];
    clipped  <= clip12 || satx || saty;
  end

  // a result never appears without a request in flight
  a_done_src: assert property (@(posedge clk) disable iff (rst) done |-> $past(v12))
    else $error("result without request");
  a_v1: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> v1)
    else $error("request lost at entry");
  a_v5_v6: assert property (@(posedge clk) disable iff (rst) v5 |=> v6)
    else $error("request lost in horner pipeline");

endmodule

>>> test/radial_lens_distortion_map_unit_tb.sv
module radial_lens_distortion_map_unit_tb;
  import rldm_pkg::*;

  localparam int unsigned LatencyCycles = 30;
  localparam int unsigned WatchdogLimit = 4000;

  // source map scoreboard: predicts each request and checks results in order
  class source_map_scoreboard;
    logic [15:0] ca, cb, cc, cd, rscale;
    logic [11:0] cx2, cy2;
    logic [15:0] exp_x[$];
    logic [15:0] exp_y[$];
    logic        exp_clip[$];
    int          errors;

    function new();
      ca = 16'd1229; cb = 16'd0; cc = 16'd410; cd = 16'd4096;
      rscale = 16'd273; cx2 = 12'd640; cy2 = 12'd480;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_COEF_A:       ca = val;
        REG_COEF_B:       cb = val;
        REG_COEF_C:       cc = val;
        REG_COEF_D:       cd = val;
        REG_RADIUS_SCALE: rscale = val;
        REG_CENTER_X2:    cx2 = val[11:0];
        REG_CENTER_Y2:    cy2 = val[11:0];
        default: ;
      endcase
    endfunction

    // rounded division by a power of two, ties away from zero
    function longint rnd_shift(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
    endfunction

    function longint isqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = longint'(1) << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function longint sat16(longint v, ref logic flag);
      if (v > 32767) begin flag = 1'b1; return 32767; end
      if (v < -32768) begin flag = 1'b1; return -32768; end
      return v;
    endfunction

    function void note_request(logic [9:0] px_in, logic [9:0] py_in);
      longint px, py, dx2, dy2, rn, f, sx, sy;
      longint unsigned sumsq, r4, rnu;
      logic clip;
      clip = 1'b0;
      px = px_in; py = py_in;
      if (px > 1023) px = 1023;
      if (py > 1023) py = 1023;
      dx2 = 2 * px + 1 - longint'(cx2);
      dy2 = 2 * py + 1 - longint'(cy2);
      sumsq = dx2 * dx2 + dy2 * dy2;
      r4 = isqrt(sumsq << 8);
      rnu = (r4 * rscale + 256) >> 9;
      if (rnu > 65535) begin rnu = 65535; clip = 1'b1; end
      rn = rnu;
      // horner evaluation of the radial factor
      f = rnd_shift(longint'($signed(ca)) * rn, 12) + longint'($signed(cb));
      f = rnd_shift(f * rn, 12) + longint'($signed(cc));
      f = rnd_shift(f * rn, 12) + longint'($signed(cd));
      sx = rnd_shift(dx2 * f, 9) + 8 * longint'(cx2);
      sy = rnd_shift(dy2 * f, 9) + 8 * longint'(cy2);
      sx = sat16(sx, clip);
      sy = sat16(sy, clip);
      exp_x.push_back(sx[15:0]);
      exp_y.push_back(sy[15:0]);
      exp_clip.push_back(clip);
    endfunction

    function void check_result(logic [15:0] ax, logic [15:0] ay, logic aclip);
      logic [15:0] ex, ey;
      logic eclip;
      if (exp_x.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h clipped=%b", $time, ax, ay, aclip);
        errors++;
        return;
      end
      ex = exp_x.pop_front(); ey = exp_y.pop_front(); eclip = exp_clip.pop_front();
      if (ax !== ex) begin
        $display("%0t: source_x expected %h actual %h", $time, ex, ax);
        errors++;
      end
      if (ay !== ey) begin
        $display("%0t: source_y expected %h actual %h", $time, ey, ay);
        errors++;
      end
      if (aclip !== eclip) begin
        $display("%0t: clipped expected %b actual %b", $time, eclip, aclip);
        errors++;
      end
    endfunction

    function int pending();
      return exp_x.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [9:0] pixel_x = '0;
  logic [9:0] pixel_y = '0;
  logic done;
  logic signed [15:0] source_x, source_y;
  logic clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  source_map_scoreboard sb = new();
  int idle_cycles = 0;
  bit calm = 1'b0;

  radial_lens_distortion_map_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
    .source_x(source_x), .source_y(source_y), .clipped(clipped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // result monitor and request tracker
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(source_x, source_y, clipped);
      if (start && !busy) sb.note_request(pixel_x, pixel_y);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles with no accepted request, result or configuration write
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_pixel(logic [9:0] x, logic [9:0] y);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setting();
    write_cfg(REG_COEF_A, 16'($urandom_range(0, 65535)));
    write_cfg(REG_COEF_B, 16'($urandom_range(0, 65535)));
    write_cfg(REG_COEF_C, 16'($urandom_range(0, 65535)));
    write_cfg(REG_COEF_D, 16'($urandom_range(0, 65535)));
    write_cfg(REG_RADIUS_SCALE, 16'($urandom_range(0, 65535)));
    write_cfg(REG_CENTER_X2, 16'($urandom_range(0, 4095)));
    write_cfg(REG_CENTER_Y2, 16'($urandom_range(0, 4095)));
  endtask

  task automatic random_burst(int n);
    repeat (n) send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corners and centre with reset setting
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd320, 10'd240);
    send_pixel(10'd319, 10'd239);
    drain();

    // extreme registers: radius saturation and coordinate clipping
    write_cfg(REG_COEF_A, 16'h7fff);
    write_cfg(REG_COEF_B, 16'h7fff);
    write_cfg(REG_COEF_C, 16'h7fff);
    write_cfg(REG_COEF_D, 16'h7fff);
    write_cfg(REG_RADIUS_SCALE, 16'hffff);
    write_cfg(REG_CENTER_X2, 16'd0);
    write_cfg(REG_CENTER_Y2, 16'd0);
    write_cfg(3'd7, 16'h1234);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd3);
    drain();

    write_cfg(REG_COEF_A, 16'h8000);
    write_cfg(REG_COEF_B, 16'h8000);
    write_cfg(REG_COEF_C, 16'h8000);
    write_cfg(REG_COEF_D, 16'h8000);
    write_cfg(REG_RADIUS_SCALE, 16'd0);
    write_cfg(REG_CENTER_X2, 16'hffff);
    write_cfg(REG_CENTER_Y2, 16'd2048);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd700, 10'd100);
    drain();

    write_cfg(REG_RADIUS_SCALE, 16'd273);
    write_cfg(REG_CENTER_X2, 16'd2048);
    write_cfg(REG_COEF_D, 16'd4096);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    drain();

    // random phases with fresh settings
    repeat (8) begin
      random_setting();
      random_burst(150);
      drain();
    end

    // back to default-like setting and a busy stretch
    write_cfg(REG_COEF_A, 16'd1229);
    write_cfg(REG_COEF_B, 16'd0);
    write_cfg(REG_COEF_C, 16'd410);
    write_cfg(REG_COEF_D, 16'd4096);
    write_cfg(REG_RADIUS_SCALE, 16'd273);
    write_cfg(REG_CENTER_X2, 16'd640);
    write_cfg(REG_CENTER_Y2, 16'd480);
    random_burst(300);
    calm = 1'b1;
    random_burst(350);
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/rldm_pkg.sv
hdl/rldm_sqrt.sv
hdl/radial_lens_distortion_map_unit.sv
test/radial_lens_distortion_map_unit_tb.sv
